// File: hw/rtl/wuau_pkg.sv
// Package for the wide unsigned arithmetic unit.
// Holds default sizes, request, operation and status codes, and the controller state type.
package wuau_pkg;
	localparam int WIDTH_DEF     = 1024;
	localparam int WORD_BITS_DEF = 64;

	localparam logic [1:0] REQ_LOAD_A = 2'd0;
	localparam logic [1:0] REQ_LOAD_B = 2'd1;
	localparam logic [1:0] REQ_RUN    = 2'd2;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_MOD = 3'd4;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_OVF  = 2'd1;
	localparam logic [1:0] ST_UNF  = 2'd2;
	localparam logic [1:0] ST_DIV0 = 2'd3;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PASS,
		S_OUT
	} state_t;
endpackage

// File: hw/rtl/wide_unsigned_arith_unit_core.sv
// Wide unsigned arithmetic unit: add, subtract, multiply, divide and modulo.
// Word-serial datapath over rotating operand registers; uses wuau_pkg.
//
// Usage: raise start with req_type and its fields; the transaction is taken
// at a rising edge where start is high and busy is low. Loads of A or B
// (req_type 0 or 1) write one word and finish at once; busy stays low.
// A run (req_type 2, op_code 0..4) raises busy, works, then shows NWORDS
// result words on consecutive cycles, lowest first, each marked by
// result_valid for one cycle, with last on the final word. The receiver
// cannot stall; words are never held. Unknown op or req codes are dropped.
// Each pass moves one word per cycle through a word-wide adder and
// subtractor. Add and subtract take one pass, multiply and divide/modulo
// take WIDTH passes (shift-add and restoring division, one bit per pass).
// One run is in progress at a time.
// Reset clears control state and both operands to zero.
module wide_unsigned_arith_unit_core #(
	parameter int WIDTH     = wuau_pkg::WIDTH_DEF,
	parameter int WORD_BITS = wuau_pkg::WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [1:0]           req_type,
	input  logic [3:0]           word_index,
	input  logic [63:0]          word_data,
	input  logic [2:0]           op_code,
	output logic                 result_valid,
	output logic [63:0]          result_word,
	output logic [3:0]           result_index,
	output logic [1:0]           status,
	output logic                 last
);
	import wuau_pkg::*;

	localparam int NWORDS = WIDTH / WORD_BITS;
	localparam int WCW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int ICW    = $clog2(WIDTH);
	localparam logic [WCW-1:0] WLAST = WCW'(NWORDS - 1);
	localparam logic [ICW-1:0] ILAST = ICW'(WIDTH - 1);

	state_t state_q, state_d;

	logic [WIDTH-1:0] a_q, b_q, r_q, t_q, q_q, o_q;
	logic [2:0]       op_q;
	logic             c_q, shin_q, ovf_q, zero_q;
	logic [WCW-1:0]   wcnt_q;
	logic [ICW-1:0]   icnt_q;
	logic [1:0]       st_q;

	logic                 take_run, pass_end, run_end;
	logic [WORD_BITS-1:0] aw, bw, rw, sw, addend, sum_w, dif_w;
	logic                 cout, bout, take;
	logic [WIDTH-1:0]     r_rot, t_rot, r_nx, q_nx;
	logic [1:0]           st_fin;

	assign take_run = start && !busy && req_type == REQ_RUN && op_code <= OP_MOD;
	assign pass_end = state_q == S_PASS && wcnt_q == WLAST;
	assign run_end  = pass_end && (op_q == OP_ADD || op_q == OP_SUB || icnt_q == ILAST);

	assign aw = a_q[WORD_BITS-1:0];
	assign bw = b_q[WORD_BITS-1:0];
	assign rw = r_q[WORD_BITS-1:0];
	assign sw = {rw[WORD_BITS-2:0], shin_q};

	always_comb begin
		addend = '0;
		if (op_q == OP_MUL && q_q[WIDTH-1])
			addend = aw;
		if (op_q == OP_MUL)
			{cout, sum_w} = {1'b0, sw} + {1'b0, addend} + {{WORD_BITS{1'b0}}, c_q};
		else
			{cout, sum_w} = {1'b0, aw} + {1'b0, bw} + {{WORD_BITS{1'b0}}, c_q};
		if (op_q == OP_SUB)
			{bout, dif_w} = {1'b0, aw} - {1'b0, bw} - {{WORD_BITS{1'b0}}, c_q};
		else
			{bout, dif_w} = {1'b0, sw} - {1'b0, bw} - {{WORD_BITS{1'b0}}, c_q};
		r_rot = r_q >> WORD_BITS;
		t_rot = t_q >> WORD_BITS;
		case (op_q)
			OP_ADD, OP_MUL: r_rot[WIDTH-1 -: WORD_BITS] = sum_w;
			OP_SUB:         r_rot[WIDTH-1 -: WORD_BITS] = dif_w;
			default:        r_rot[WIDTH-1 -: WORD_BITS] = sw;
		endcase
		t_rot[WIDTH-1 -: WORD_BITS] = dif_w;
		take = rw[WORD_BITS-1] || !bout;
		r_nx = r_rot;
		q_nx = q_q;
		if (op_q == OP_DIV || op_q == OP_MOD) begin
			if (take)
				r_nx = t_rot;
			q_nx = {q_q[WIDTH-2:0], take};
		end else if (op_q == OP_MUL) begin
			q_nx = {q_q[WIDTH-2:0], 1'b0};
		end
		case (op_q)
			OP_ADD:  st_fin = cout ? ST_OVF : ST_OK;
			OP_SUB:  st_fin = bout ? ST_UNF : ST_OK;
			OP_MUL:  st_fin = (ovf_q || cout || rw[WORD_BITS-1]) ? ST_OVF : ST_OK;
			default: st_fin = zero_q ? ST_DIV0 : ST_OK;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (take_run) state_d = S_PASS;
			S_PASS:  if (run_end) state_d = S_OUT;
			S_OUT:   if (wcnt_q == WLAST) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		busy         = state_q != S_IDLE;
		result_valid = state_q == S_OUT;
		result_word  = 64'(o_q[WORD_BITS-1:0]);
		result_index = 4'(wcnt_q);
		status       = st_q;
		last         = state_q == S_OUT && wcnt_q == WLAST;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			a_q     <= '0;
			b_q     <= '0;
			wcnt_q  <= '0;
			icnt_q  <= '0;
			st_q    <= ST_OK;
		end else begin
			state_q <= state_d;
			if (start && !busy && {28'd0, word_index} < NWORDS) begin
				if (req_type == REQ_LOAD_A)
					a_q[word_index*WORD_BITS +: WORD_BITS] <= word_data[WORD_BITS-1:0];
				if (req_type == REQ_LOAD_B)
					b_q[word_index*WORD_BITS +: WORD_BITS] <= word_data[WORD_BITS-1:0];
			end
			if (take_run) begin
				wcnt_q <= '0;
				icnt_q <= '0;
			end else if (state_q == S_PASS) begin
				a_q    <= {aw, a_q[WIDTH-1:WORD_BITS]};
				b_q    <= {bw, b_q[WIDTH-1:WORD_BITS]};
				wcnt_q <= pass_end ? '0 : wcnt_q + 1'b1;
				if (pass_end)
					icnt_q <= icnt_q + 1'b1;
				if (run_end)
					st_q <= st_fin;
			end else if (state_q == S_OUT) begin
				wcnt_q <= wcnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_run) begin
			op_q   <= op_code;
			zero_q <= b_q == '0;
			r_q    <= '0;
			t_q    <= '0;
			q_q    <= (op_code == OP_MUL) ? b_q : a_q;
			c_q    <= 1'b0;
			ovf_q  <= 1'b0;
			shin_q <= (op_code == OP_MUL) ? 1'b0 : a_q[WIDTH-1];
		end else if (state_q == S_PASS) begin
			t_q <= t_rot;
			if (pass_end) begin
				r_q    <= r_nx;
				q_q    <= q_nx;
				c_q    <= 1'b0;
				ovf_q  <= ovf_q || cout || rw[WORD_BITS-1];
				shin_q <= (op_q == OP_MUL) ? 1'b0 : q_q[WIDTH-2];
				if (run_end)
					o_q <= (st_fin != ST_OK) ? '0 : (op_q == OP_DIV ? q_nx : r_nx);
			end else begin
				r_q    <= r_rot;
				c_q    <= (op_q == OP_SUB || op_q == OP_DIV || op_q == OP_MOD) ? bout : cout;
				shin_q <= rw[WORD_BITS-1];
			end
		end else if (state_q == S_OUT) begin
			o_q <= o_q >> WORD_BITS;
		end
	end
endmodule

// File: hw/rtl/wuau_checker.sv
// Port-level checks for the wide unsigned arithmetic unit.
// Depends on wide_unsigned_arith_unit_core, to which it is bound below.
module wuau_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       busy,
	input logic       result_valid,
	input logic [3:0] result_index,
	input logic [1:0] status,
	input logic       last
);
	a_valid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy) else $error("result without busy");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |=> !busy) else $error("busy after last word");
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |=> result_valid && result_index == $past(result_index) + 4'd1)
		else $error("result burst broken");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |=> $stable(status)) else $error("status changed in a run");
endmodule

bind wide_unsigned_arith_unit_core wuau_checker u_wuau_checker (
	.clk(clk), .arst_n(arst_n), .busy(busy), .result_valid(result_valid),
	.result_index(result_index), .status(status), .last(last)
);

// File: sim/tb_top.sv
// Testbench for wide_unsigned_arith_unit_core: loads operands word by word and runs every op.
// Predicts each result word from shadow copies of A and B; depends on wuau_pkg and the core.
`timescale 1ns / 1ps

module tb_top;
	import wuau_pkg::*;

	localparam int NW = WIDTH_DEF / WORD_BITS_DEF;

	typedef struct {
		logic [63:0] word;
		logic [3:0]  index;
		logic [1:0]  status;
		logic        last;
	} res_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  req_type = REQ_LOAD_A;
	logic [3:0]  word_index = '0;
	logic [63:0] word_data = '0;
	logic [2:0]  op_code = OP_ADD;
	logic        result_valid;
	logic [63:0] result_word;
	logic [3:0]  result_index;
	logic [1:0]  status;
	logic        last;

	logic [WIDTH_DEF-1:0] shadow_a = '0;
	logic [WIDTH_DEF-1:0] shadow_b = '0;
	res_word_t            pending_words[$];
	int                   errors = 0;
	int                   counted = 0;
	int                   stall_cnt = 0;
	bit                   allow_idle = 1'b1;

	wide_unsigned_arith_unit_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.req_type(req_type), .word_index(word_index), .word_data(word_data),
		.op_code(op_code), .result_valid(result_valid), .result_word(result_word),
		.result_index(result_index), .status(status), .last(last)
	);

	always #2 clk = ~clk;

	task automatic predict_run(input logic [2:0] op);
		logic [WIDTH_DEF:0]     sum;
		logic [2*WIDTH_DEF-1:0] prod;
		logic [WIDTH_DEF-1:0]   val;
		logic [1:0]             st;
		res_word_t              r;
		val = '0;
		st = ST_OK;
		case (op)
			OP_ADD: begin
				sum = {1'b0, shadow_a} + {1'b0, shadow_b};
				val = sum[WIDTH_DEF-1:0];
				if (sum[WIDTH_DEF]) st = ST_OVF;
			end
			OP_SUB: begin
				if (shadow_a < shadow_b) st = ST_UNF;
				else val = shadow_a - shadow_b;
			end
			OP_MUL: begin
				prod = {{WIDTH_DEF{1'b0}}, shadow_a} * {{WIDTH_DEF{1'b0}}, shadow_b};
				val = prod[WIDTH_DEF-1:0];
				if (prod[2*WIDTH_DEF-1:WIDTH_DEF] != '0) st = ST_OVF;
			end
			default: begin
				if (shadow_b == '0) st = ST_DIV0;
				else if (op == OP_DIV) val = shadow_a / shadow_b;
				else val = shadow_a % shadow_b;
			end
		endcase
		if (st != ST_OK) val = '0;
		for (int k = 0; k < NW; k++) begin
			r.word = val[k*64 +: 64];
			r.index = 4'(k);
			r.status = st;
			r.last = (k == NW - 1);
			pending_words.push_back(r);
		end
	endtask

	task automatic send(input logic [1:0] rq, input logic [3:0] idx, input logic [63:0] data,
			input logic [2:0] op);
		if (allow_idle && $urandom_range(0, 2) == 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(0, 3)) @(negedge clk);
		end
		@(negedge clk);
		start = 1'b1;
		req_type = rq;
		word_index = idx;
		word_data = data;
		op_code = op;
		do @(posedge clk); while (busy);
		if (rq == REQ_LOAD_A) shadow_a[idx*64 +: 64] = data;
		else if (rq == REQ_LOAD_B) shadow_b[idx*64 +: 64] = data;
		else if (rq == REQ_RUN && op <= OP_MOD) predict_run(op);
		if (rq != 2'd3 && !(rq == REQ_RUN && op > OP_MOD)) counted++;
	endtask

	task automatic load_operand(input logic [1:0] rq, input logic [WIDTH_DEF-1:0] v);
		for (int k = 0; k < NW; k++) send(rq, 4'(k), v[k*64 +: 64], OP_ADD);
	endtask

	function automatic logic [63:0] rand_word();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 64'(1) << $urandom_range(0, 63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	always @(posedge clk) begin
		if (result_valid) begin
			if (pending_words.size() == 0) begin
				$display("%0t unexpected result: exp none got word %h idx %0d", $time,
					result_word, result_index);
				errors++;
			end else begin
				res_word_t e;
				e = pending_words.pop_front();
				if (result_word !== e.word) begin
					$display("%0t result_word: exp %h got %h", $time, e.word, result_word);
					errors++;
				end
				if (result_index !== e.index) begin
					$display("%0t result_index: exp %0d got %0d", $time, e.index, result_index);
					errors++;
				end
				if (status !== e.status) begin
					$display("%0t status: exp %0d got %0d", $time, e.status, status);
					errors++;
				end
				if (last !== e.last) begin
					$display("%0t last: exp %0b got %0b", $time, e.last, last);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid) stall_cnt <= 0;
		else stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= 100000) begin
			$display("wide_unsigned_arith_unit_core: mismatch");
			$finish;
		end
	end

	task automatic test_extremes();
		load_operand(REQ_LOAD_A, '1);
		send(REQ_LOAD_B, 4'd0, 64'd1, OP_ADD);
		for (int op = OP_ADD; op <= OP_MOD; op++) send(REQ_RUN, 4'd0, '0, 3'(op));
	endtask

	task automatic test_errors();
		send(REQ_LOAD_B, 4'd0, 64'd0, OP_ADD);
		send(REQ_RUN, 4'd0, '0, OP_DIV);
		send(REQ_RUN, 4'd0, '0, OP_MOD);
		send(REQ_LOAD_A, 4'd15, 64'd0, OP_ADD);
		send(REQ_LOAD_B, 4'd15, 64'd1, OP_ADD);
		send(REQ_RUN, 4'd0, '0, OP_SUB);
		send(REQ_RUN, 4'd0, '0, OP_MUL);
	endtask

	task automatic test_ignored();
		send(REQ_RUN, 4'd3, '1, 3'd5);
		send(REQ_RUN, 4'd9, '1, 3'd7);
		send(2'd3, 4'd15, '1, 3'd6);
		send(REQ_RUN, 4'd0, '0, OP_ADD);
	endtask

	task automatic test_random();
		int         nloads;
		logic [2:0] op;
		while (counted < 125) begin
			if (counted > 100) allow_idle = 1'b0;
			op = 3'($urandom_range(0, 4));
			if (op == OP_MUL && $urandom_range(0, 1) == 0)
				for (int k = NW / 2; k < NW; k++) begin
					send(REQ_LOAD_A, 4'(k), '0, 3'($urandom_range(0, 7)));
					send(REQ_LOAD_B, 4'(k), '0, 3'($urandom_range(0, 7)));
				end
			nloads = $urandom_range(1, 4);
			for (int n = 0; n < nloads; n++)
				send(2'($urandom_range(0, 1)), 4'($urandom_range(0, 15)), rand_word(),
					3'($urandom_range(0, 7)));
			if ($urandom_range(0, 7) == 0)
				send(2'($urandom_range(2, 3)), 4'($urandom), rand_word(), 3'($urandom_range(5, 7)));
			send(REQ_RUN, 4'($urandom), rand_word(), op);
		end
	endtask

	initial begin
		int guard;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		test_extremes();
		test_errors();
		test_ignored();
		test_random();
		@(negedge clk);
		start = 1'b0;
		guard = 0;
		while (pending_words.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (40) @(posedge clk);
		if (errors == 0 && pending_words.size() == 0)
			$display("wide_unsigned_arith_unit_core: match");
		else
			$display("wide_unsigned_arith_unit_core: mismatch");
		$finish;
	end
endmodule
